### src/cpu6502_execute_unit_top_assert.svh
// Assertion macros for the execute unit.
`ifndef CPU6502_EXECUTE_UNIT_TOP_ASSERT_SVH
`define CPU6502_EXECUTE_UNIT_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define C6502EU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define C6502EU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/c6502eu_pkg.sv
package c6502eu_pkg;

    typedef enum logic [5:0] {
        FN_LDA = 6'd0,  FN_LDX = 6'd1,  FN_LDY = 6'd2,  FN_STA = 6'd3,
        FN_STX = 6'd4,  FN_STY = 6'd5,  FN_TAX = 6'd6,  FN_TAY = 6'd7,
        FN_TSX = 6'd8,  FN_TXA = 6'd9,  FN_TXS = 6'd10, FN_TYA = 6'd11,
        FN_PHA = 6'd12, FN_PHP = 6'd13, FN_PLA = 6'd14, FN_PLP = 6'd15,
        FN_DEX = 6'd16, FN_DEY = 6'd17, FN_INX = 6'd18, FN_INY = 6'd19,
        FN_INC = 6'd20, FN_DEC = 6'd21, FN_ADC = 6'd22, FN_SBC = 6'd23,
        FN_AND = 6'd24, FN_EOR = 6'd25, FN_ORA = 6'd26, FN_ASL = 6'd27,
        FN_ROL = 6'd28, FN_LSR = 6'd29, FN_ROR = 6'd30, FN_CLC = 6'd31,
        FN_CLD = 6'd32, FN_CLI = 6'd33, FN_CLV = 6'd34, FN_SEC = 6'd35,
        FN_SED = 6'd36, FN_SEI = 6'd37, FN_CMP = 6'd38, FN_CPX = 6'd39,
        FN_CPY = 6'd40, FN_BIT = 6'd41, FN_BRANCH = 6'd42, FN_NOP = 6'd43
    } t_func;

    typedef enum logic [2:0] {
        BR_CC = 3'd0, BR_CS = 3'd1, BR_EQ = 3'd2, BR_MI = 3'd3,
        BR_NE = 3'd4, BR_PL = 3'd5, BR_VC = 3'd6, BR_VS = 3'd7
    } t_branch;

    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_I = 2;
    localparam int unsigned FLAG_D = 3;
    localparam int unsigned FLAG_B = 4;
    localparam int unsigned FLAG_U = 5;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_N = 7;

    localparam logic [7:0] RESET_A  = 8'h00;
    localparam logic [7:0] RESET_X  = 8'h00;
    localparam logic [7:0] RESET_Y  = 8'h00;
    localparam logic [7:0] RESET_SP = 8'hFF;
    localparam logic [7:0] RESET_P  = 8'h24;
    localparam logic [7:0] PUSH_P_MASK = 8'h30;

endpackage

### src/cpu6502_execute_unit_top.sv
// Channel  | Handshake                | Payload
// in       | i_in_valid / o_in_ready  | i_func, i_operand_byte, i_on_accumulator, i_branch_cond
// out      | o_out_valid / i_out_ready| o_write_data, o_write_enable, o_stack_slot,
//          |                          | o_branch_taken, o_status_out, o_reg_{a,x,y,sp}_out
// One transaction per cycle sustained while i_out_ready is high; path is input register, then result register.
// The ALU and flag logic between the two registers sets the clock; A, X, Y, SP and P
// update when a transaction moves from the input register into the result register.
// While the result register is stalled the input register still takes one transaction.
// Synchronous active-low reset: A=X=Y=0, SP=FF, P=24, both stages empty.
`include "cpu6502_execute_unit_top_assert.svh"

module cpu6502_execute_unit_top
    import c6502eu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [5:0] i_func,
    input  logic [7:0] i_operand_byte,
    input  logic       i_on_accumulator,
    input  logic [2:0] i_branch_cond,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_write_data,
    output logic       o_write_enable,
    output logic [7:0] o_stack_slot,
    output logic       o_branch_taken,
    output logic [7:0] o_status_out,
    output logic [7:0] o_reg_a_out,
    output logic [7:0] o_reg_x_out,
    output logic [7:0] o_reg_y_out,
    output logic [7:0] o_reg_sp_out
);

    logic       r_in_valid;
    logic [5:0] r_func;
    logic [7:0] r_operand;
    logic       r_on_acc;
    logic [2:0] r_cond;

    logic [7:0] r_a, r_x, r_y, r_sp, r_p;
    logic [7:0] n_a, n_x, n_y, n_sp, n_p;

    logic       r_out_valid;
    logic [7:0] r_out_wdata, r_out_slot;
    logic       r_out_wen, r_out_taken;
    logic [7:0] n_wdata, n_slot;
    logic       n_wen, n_taken;

    logic       advance;

    logic [8:0] adc_sum;
    logic [7:0] adc_m;
    logic [7:0] shift_src, shift_res;
    logic       shift_carry;
    logic [7:0] cmp_reg;
    logic [8:0] cmp_diff;
    logic [7:0] nz_val;
    logic       nz_upd;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign adc_m   = (r_func == FN_SBC) ? ~r_operand : r_operand;
    assign adc_sum = {1'b0, r_a} + {1'b0, adc_m} + {8'd0, r_p[FLAG_C]};

    assign shift_src = r_on_acc ? r_a : r_operand;

    always_comb begin
        shift_res   = shift_src;
        shift_carry = 1'b0;
        case (r_func)
            FN_ASL: begin
                shift_res   = {shift_src[6:0], 1'b0};
                shift_carry = shift_src[7];
            end
            FN_ROL: begin
                shift_res   = {shift_src[6:0], r_p[FLAG_C]};
                shift_carry = shift_src[7];
            end
            FN_LSR: begin
                shift_res   = {1'b0, shift_src[7:1]};
                shift_carry = shift_src[0];
            end
            FN_ROR: begin
                shift_res   = {r_p[FLAG_C], shift_src[7:1]};
                shift_carry = shift_src[0];
            end
            default: begin
                shift_res   = shift_src;
                shift_carry = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (r_func)
            FN_CPX:  cmp_reg = r_x;
            FN_CPY:  cmp_reg = r_y;
            default: cmp_reg = r_a;
        endcase
    end
    // bit 8 set means borrow, i.e. register < operand
    assign cmp_diff = {1'b0, cmp_reg} - {1'b0, r_operand};

    always_comb begin
        n_a     = r_a;
        n_x     = r_x;
        n_y     = r_y;
        n_sp    = r_sp;
        n_p     = r_p;
        n_wdata = 8'd0;
        n_wen   = 1'b0;
        n_slot  = 8'd0;
        n_taken = 1'b0;
        nz_val  = 8'd0;
        nz_upd  = 1'b0;
        case (r_func)
            FN_LDA: begin n_a = r_operand; nz_val = r_operand; nz_upd = 1'b1; end
            FN_LDX: begin n_x = r_operand; nz_val = r_operand; nz_upd = 1'b1; end
            FN_LDY: begin n_y = r_operand; nz_val = r_operand; nz_upd = 1'b1; end
            FN_STA: begin n_wdata = r_a; n_wen = 1'b1; end
            FN_STX: begin n_wdata = r_x; n_wen = 1'b1; end
            FN_STY: begin n_wdata = r_y; n_wen = 1'b1; end
            FN_TAX: begin n_x = r_a; nz_val = r_a; nz_upd = 1'b1; end
            FN_TAY: begin n_y = r_a; nz_val = r_a; nz_upd = 1'b1; end
            FN_TSX: begin n_x = r_sp; nz_val = r_sp; nz_upd = 1'b1; end
            FN_TXA: begin n_a = r_x; nz_val = r_x; nz_upd = 1'b1; end
            FN_TXS: begin n_sp = r_x; end
            FN_TYA: begin n_a = r_y; nz_val = r_y; nz_upd = 1'b1; end
            FN_PHA, FN_PHP: begin
                n_wdata = (r_func == FN_PHA) ? r_a : (r_p | PUSH_P_MASK);
                n_wen   = 1'b1;
                n_slot  = r_sp;
                n_sp    = r_sp - 8'd1;
            end
            FN_PLA: begin
                n_sp   = r_sp + 8'd1;
                n_slot = r_sp + 8'd1;
                n_a    = r_operand;
                n_p[FLAG_B] = 1'b0;
                nz_val = r_operand;
                nz_upd = 1'b1;
            end
            FN_PLP: begin
                n_sp   = r_sp + 8'd1;
                n_slot = r_sp + 8'd1;
                n_p    = r_operand;
                n_p[FLAG_B] = 1'b0;
            end
            FN_DEX: begin n_x = r_x - 8'd1; nz_val = r_x - 8'd1; nz_upd = 1'b1; end
            FN_DEY: begin n_y = r_y - 8'd1; nz_val = r_y - 8'd1; nz_upd = 1'b1; end
            FN_INX: begin n_x = r_x + 8'd1; nz_val = r_x + 8'd1; nz_upd = 1'b1; end
            FN_INY: begin n_y = r_y + 8'd1; nz_val = r_y + 8'd1; nz_upd = 1'b1; end
            FN_INC: begin
                n_wdata = r_operand + 8'd1; n_wen = 1'b1;
                nz_val  = r_operand + 8'd1; nz_upd = 1'b1;
            end
            FN_DEC: begin
                n_wdata = r_operand - 8'd1; n_wen = 1'b1;
                nz_val  = r_operand - 8'd1; nz_upd = 1'b1;
            end
            FN_ADC, FN_SBC: begin
                n_a = adc_sum[7:0];
                n_p[FLAG_C] = adc_sum[8];
                n_p[FLAG_V] = ~(r_a[7] ^ adc_m[7]) & (r_a[7] ^ adc_sum[7]);
                nz_val = adc_sum[7:0];
                nz_upd = 1'b1;
            end
            FN_AND: begin n_a = r_a & r_operand; nz_val = r_a & r_operand; nz_upd = 1'b1; end
            FN_EOR: begin n_a = r_a ^ r_operand; nz_val = r_a ^ r_operand; nz_upd = 1'b1; end
            FN_ORA: begin n_a = r_a | r_operand; nz_val = r_a | r_operand; nz_upd = 1'b1; end
            FN_ASL, FN_ROL, FN_LSR, FN_ROR: begin
                if (r_on_acc) begin
                    n_a = shift_res;
                end else begin
                    n_wdata = shift_res;
                    n_wen   = 1'b1;
                end
                n_p[FLAG_C] = shift_carry;
                nz_val = shift_res;
                nz_upd = 1'b1;
            end
            FN_CLC: n_p[FLAG_C] = 1'b0;
            FN_CLD: n_p[FLAG_D] = 1'b0;
            FN_CLI: n_p[FLAG_I] = 1'b0;
            FN_CLV: n_p[FLAG_V] = 1'b0;
            FN_SEC: n_p[FLAG_C] = 1'b1;
            FN_SED: n_p[FLAG_D] = 1'b1;
            FN_SEI: n_p[FLAG_I] = 1'b1;
            FN_CMP, FN_CPX, FN_CPY: begin
                n_p[FLAG_C] = ~cmp_diff[8];
                n_p[FLAG_Z] = (cmp_reg == r_operand);
                n_p[FLAG_N] = cmp_diff[7];
            end
            FN_BIT: begin
                n_p[FLAG_Z] = ((r_a & r_operand) == 8'd0);
                n_p[FLAG_V] = r_operand[6];
                n_p[FLAG_N] = r_operand[7];
            end
            FN_BRANCH: begin
                case (r_cond)
                    BR_CC:   n_taken = ~r_p[FLAG_C];
                    BR_CS:   n_taken = r_p[FLAG_C];
                    BR_EQ:   n_taken = r_p[FLAG_Z];
                    BR_MI:   n_taken = r_p[FLAG_N];
                    BR_NE:   n_taken = ~r_p[FLAG_Z];
                    BR_PL:   n_taken = ~r_p[FLAG_N];
                    BR_VC:   n_taken = ~r_p[FLAG_V];
                    BR_VS:   n_taken = r_p[FLAG_V];
                    default: n_taken = 1'b0;
                endcase
            end
            default: begin
                n_a = r_a;
            end
        endcase
        if (nz_upd) begin
            n_p[FLAG_Z] = (nz_val == 8'd0);
            n_p[FLAG_N] = nz_val[7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_func    <= i_func;
            r_operand <= i_operand_byte;
            r_on_acc  <= i_on_accumulator;
            r_cond    <= i_branch_cond;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a  <= RESET_A;
            r_x  <= RESET_X;
            r_y  <= RESET_Y;
            r_sp <= RESET_SP;
            r_p  <= RESET_P;
        end else if (advance) begin
            r_a  <= n_a;
            r_x  <= n_x;
            r_y  <= n_y;
            r_sp <= n_sp;
            r_p  <= n_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_wdata <= n_wdata;
            r_out_wen   <= n_wen;
            r_out_slot  <= n_slot;
            r_out_taken <= n_taken;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_write_data   = r_out_wdata;
    assign o_write_enable = r_out_wen;
    assign o_stack_slot   = r_out_slot;
    assign o_branch_taken = r_out_taken;
    // registers stay put until the next commit, so they double as the result payload
    assign o_status_out   = r_p;
    assign o_reg_a_out    = r_a;
    assign o_reg_x_out    = r_x;
    assign o_reg_y_out    = r_y;
    assign o_reg_sp_out   = r_sp;

    `C6502EU_ASSERT_NOW(a_b_flag_clear, 1'b1, !r_p[FLAG_B], "B flag set in P")
    `C6502EU_ASSERT_NEXT(a_state_hold, !advance, $stable(r_a) && $stable(r_x) && $stable(r_y) && $stable(r_sp) && $stable(r_p), "state changed without commit")
    `C6502EU_ASSERT_NEXT(a_push_sp, advance && (r_func == FN_PHA || r_func == FN_PHP), r_sp == $past(r_sp) - 8'd1 && r_out_wen, "push did not decrement SP")
    `C6502EU_ASSERT_NEXT(a_taken_only_branch, advance && r_func != FN_BRANCH, !r_out_taken, "branch taken outside branch op")
    `C6502EU_ASSERT_NOW(a_ready_when_empty, !r_out_valid, o_in_ready, "input stalled with empty output")

endmodule
